>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CIE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CIE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cie_pkg.sv
`timescale 1ns / 1ps

package cie_pkg;

  typedef enum logic [1:0] {
    OUT_EXEC    = 2'd0,
    OUT_BRK     = 2'd1,
    OUT_UNKNOWN = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  stack_pointer;
    logic [7:0]  status_flags;
    logic [15:0] program_counter;
    logic [31:0] cycle_total;
    outcome_t    outcome;
  } out_item_t;

  localparam logic [7:0] OP_BRK     = 8'h00;
  localparam logic [7:0] OP_CLC     = 8'h18;
  localparam logic [7:0] OP_SEC     = 8'h38;
  localparam logic [7:0] OP_CLI     = 8'h58;
  localparam logic [7:0] OP_SEI     = 8'h78;
  localparam logic [7:0] OP_CLV     = 8'hB8;
  localparam logic [7:0] OP_CLD     = 8'hD8;
  localparam logic [7:0] OP_SED     = 8'hF8;
  localparam logic [7:0] OP_ADC_ZP  = 8'h65;
  localparam logic [7:0] OP_ADC_IMM = 8'h69;
  localparam logic [7:0] OP_SBC_IMM = 8'hE9;
  localparam logic [7:0] OP_STA_ZP  = 8'h85;
  localparam logic [7:0] OP_TXA     = 8'h8A;
  localparam logic [7:0] OP_TYA     = 8'h98;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_TAY     = 8'hA8;
  localparam logic [7:0] OP_TAX     = 8'hAA;
  localparam logic [7:0] OP_TSX     = 8'hBA;
  localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
  localparam logic [7:0] OP_INY     = 8'hC8;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_NOP     = 8'hEA;

  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

endpackage

>>> hw/rtl/cie_ram.sv
`timescale 1ns / 1ps

module cie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/cpu_instruction_execute.sv
`timescale 1ns / 1ps

// channel  | beat            | handshake                  | payload
// ---------+-----------------+----------------------------+------------------------
// item     | one instruction | item_valid / item_ready     | opcode, operand bytes
// result   | machine state   | result_valid / result_ready | registers, pc, cycles
//
// One instruction per cycle sustained while results are taken; an item is captured with its RAM read
// at its beat, then executes into the result register when execute advances.
// Execute forwards X to the next address and the stored byte to the next read.
// After reset the data RAM is cleared address by address, with item_ready low.
// A stalled result holds execute; the input stalls behind it.

module cpu_instruction_execute #(
  parameter int RAM_ADDR_BITS = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  cie_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output cie_pkg::out_item_t result
);

  import cie_pkg::*;

  localparam int RAM_DEPTH = 1 << RAM_ADDR_BITS;

  function automatic logic [7:0] with_zn(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[FLAG_Z] = (v == 8'h00);
    q[FLAG_N] = v[7];
    return q;
  endfunction

  logic [7:0]  acc, x, y, sp, status;
  logic [15:0] pc;
  logic [31:0] cycles;
  logic [7:0]  acc_next, x_next, y_next, sp_next, status_next;
  logic [1:0]  pc_add;
  logic [2:0]  cyc_add;
  outcome_t    outcome_next;

  logic                     clearing;
  logic [RAM_ADDR_BITS-1:0] clr_addr;

  logic     s_valid;
  in_item_t s_item;
  logic     advance;
  logic     accept;

  logic                     fwd;
  logic [7:0]               fwd_data;
  logic                     ram_we;
  logic [RAM_ADDR_BITS-1:0] ram_waddr;
  logic [7:0]               ram_wdata;
  logic [RAM_ADDR_BITS-1:0] ram_raddr;
  logic [7:0]               ram_rdata;
  logic [15:0]              rd_addr16;
  logic [15:0]              sta_addr16;
  logic [7:0]               x_fwd;
  logic [7:0]               mem_val;
  logic [7:0]               add_m;
  logic [8:0]               sum;
  logic                     sta_we;

  assign advance    = s_valid && (!result_valid || result_ready);
  assign item_ready = !clearing && (!s_valid || advance);
  assign accept     = item_valid && item_ready;

  assign x_fwd = advance ? x_next : x;

  always_comb begin
    unique case (item.opcode)
      OP_LDA_ABS: rd_addr16 = {item.operand_high, item.operand_low};
      OP_LDA_ZPX: rd_addr16 = {8'h00, item.operand_low + x_fwd};
      default:    rd_addr16 = {8'h00, item.operand_low};
    endcase
  end
  assign ram_raddr = rd_addr16[RAM_ADDR_BITS-1:0];

  assign sta_addr16 = {8'h00, s_item.operand_low};
  assign sta_we     = advance && (s_item.opcode == OP_STA_ZP);

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 8'h00;
    end else begin
      ram_we    = sta_we;
      ram_waddr = sta_addr16[RAM_ADDR_BITS-1:0];
      ram_wdata = acc;
    end
  end

  cie_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (accept),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign mem_val = fwd ? fwd_data : ram_rdata;
  assign add_m   = (s_item.opcode == OP_SBC_IMM) ? ~s_item.operand_low :
                   (s_item.opcode == OP_ADC_ZP)  ? mem_val : s_item.operand_low;
  assign sum     = {1'b0, acc} + {1'b0, add_m} + {8'h00, status[FLAG_C]};

  always_comb begin
    acc_next     = acc;
    x_next       = x;
    y_next       = y;
    sp_next      = sp;
    status_next  = status;
    pc_add       = 2'd1;
    cyc_add      = 3'd2;
    outcome_next = OUT_EXEC;
    unique case (s_item.opcode)
      OP_BRK: begin
        pc_add       = 2'd0;
        cyc_add      = 3'd0;
        outcome_next = OUT_BRK;
      end
      OP_CLC: status_next[FLAG_C] = 1'b0;
      OP_SEC: status_next[FLAG_C] = 1'b1;
      OP_CLI: status_next[FLAG_I] = 1'b0;
      OP_SEI: status_next[FLAG_I] = 1'b1;
      OP_CLV: status_next[FLAG_V] = 1'b0;
      OP_CLD: status_next[FLAG_D] = 1'b0;
      OP_SED: status_next[FLAG_D] = 1'b1;
      OP_ADC_ZP, OP_ADC_IMM, OP_SBC_IMM: begin
        acc_next            = sum[7:0];
        status_next[FLAG_C] = sum[8];
        status_next[FLAG_V] = ~(acc[7] ^ add_m[7]) & (acc[7] ^ sum[7]);
        status_next         = with_zn(status_next, sum[7:0]);
        pc_add              = 2'd2;
        cyc_add             = (s_item.opcode == OP_ADC_ZP) ? 3'd3 : 3'd2;
      end
      OP_STA_ZP: begin
        pc_add  = 2'd2;
        cyc_add = 3'd3;
      end
      OP_TXA: begin
        acc_next    = x;
        status_next = with_zn(status, x);
      end
      OP_TYA: begin
        acc_next    = y;
        status_next = with_zn(status, y);
      end
      OP_TXS: sp_next = x;
      OP_TAY: begin
        y_next      = acc;
        status_next = with_zn(status, acc);
      end
      OP_TAX: begin
        x_next      = acc;
        status_next = with_zn(status, acc);
      end
      OP_TSX: begin
        x_next      = sp;
        status_next = with_zn(status, sp);
      end
      OP_LDA_ZP: begin
        acc_next    = mem_val;
        status_next = with_zn(status, mem_val);
        pc_add      = 2'd2;
        cyc_add     = 3'd3;
      end
      OP_LDA_IMM: begin
        acc_next    = s_item.operand_low;
        status_next = with_zn(status, s_item.operand_low);
        pc_add      = 2'd2;
      end
      OP_LDA_ABS: begin
        acc_next    = mem_val;
        status_next = with_zn(status, mem_val);
        pc_add      = 2'd3;
        cyc_add     = 3'd4;
      end
      OP_LDA_ZPX: begin
        acc_next    = mem_val;
        status_next = with_zn(status, mem_val);
        pc_add      = 2'd2;
        cyc_add     = 3'd4;
      end
      OP_INY: begin
        y_next      = y + 8'd1;
        status_next = with_zn(status, y_next);
      end
      OP_INX: begin
        x_next      = x + 8'd1;
        status_next = with_zn(status, x_next);
      end
      OP_NOP: ;
      default: begin
        pc_add       = 2'd0;
        cyc_add      = 3'd0;
        outcome_next = OUT_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + {{(RAM_ADDR_BITS-1){1'b0}}, 1'b1};
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_item   <= item;
      fwd      <= sta_we && (sta_addr16[RAM_ADDR_BITS-1:0] == ram_raddr);
      fwd_data <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      x      <= '0;
      y      <= '0;
      sp     <= '0;
      status <= '0;
      pc     <= '0;
      cycles <= '0;
    end else if (advance) begin
      acc    <= acc_next;
      x      <= x_next;
      y      <= y_next;
      sp     <= sp_next;
      status <= status_next;
      pc     <= pc + {14'd0, pc_add};
      cycles <= cycles + {29'd0, cyc_add};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= '{acc:             acc_next,
                  index_x:         x_next,
                  index_y:         y_next,
                  stack_pointer:   sp_next,
                  status_flags:    status_next,
                  program_counter: pc + {14'd0, pc_add},
                  cycle_total:     cycles + {29'd0, cyc_add},
                  outcome:         outcome_next};
    end
  end

endmodule

>>> hw/rtl/cie_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cie_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input cie_pkg::in_item_t  item,
  input logic               result_valid,
  input logic               result_ready,
  input cie_pkg::out_item_t result
);

  import cie_pkg::*;

  logic item_beat;
  assign item_beat = item_valid && item_ready;

  // stalled result holds
  `CIE_ASSERT_NXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

  // waiting item beat holds
  `CIE_ASSERT_NXT(a_item_hold, clk, rst, item_valid && !item_ready, item_valid && $stable(item), "item changed while waiting")

  // RAM clear keeps the input closed right after reset
  `CIE_ASSERT_IMP(a_clear_blocks, clk, rst, $past(rst), !item_ready, "item taken during RAM clear")

  // a beat followed by an open input has executed into the result register
  `CIE_ASSERT_NXT(a_item_latency, clk, rst, $past(item_beat) && item_ready, result_valid, "beat not executed while input open")

  // outcome is one of the defined codes
  `CIE_ASSERT_IMP(a_outcome_code, clk, rst, result_valid, result.outcome <= OUT_UNKNOWN, "bad outcome code")

endmodule

bind cpu_instruction_execute cie_checker u_cie_checker (.*);
